>>> src/bsof_pkg.sv
// Shared constants, codes and widths for the box set overlap finder.
package bsof_pkg;

	// Default sizing of the box stores and coordinate width
	localparam int unsigned MAX_BOXES_DEF  = 64;
	localparam int unsigned COORD_BITS_DEF = 32;

	// Fixed field widths
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned SLOT_W   = 6;
	localparam int unsigned FIELD_W  = 32;
	localparam int unsigned CNT_W    = 7;
	localparam int unsigned MASK_W   = 64;
	localparam int unsigned CFG_IX_W = 1;

	// Item modes
	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD_FIRST  = 2'd0,
		MODE_LOAD_SECOND = 2'd1,
		MODE_RUN         = 2'd2,
		MODE_NONE        = 2'd3
	} mode_t;

	// Configuration register indexes
	localparam logic [CFG_IX_W-1:0] REG_FIRST_COUNT  = 1'd0;
	localparam logic [CFG_IX_W-1:0] REG_SECOND_COUNT = 1'd1;

endpackage

>>> src/bsof_pair_cmp.sv
// Shared box pair compare unit: inclusive overlap test on both axes.
module bsof_pair_cmp #(
	parameter int unsigned COORD_BITS = bsof_pkg::COORD_BITS_DEF
) (
	input  logic [4*COORD_BITS-1:0] a_box,
	input  logic [4*COORD_BITS-1:0] b_box,
	output logic                    hit
);
	import bsof_pkg::*;

	// box layout, low to high: x_low, x_high, y_low, y_high
	logic signed [COORD_BITS-1:0] a_xl, a_xh, a_yl, a_yh;
	logic signed [COORD_BITS-1:0] b_xl, b_xh, b_yl, b_yh;

	assign a_xl = a_box[0*COORD_BITS +: COORD_BITS];
	assign a_xh = a_box[1*COORD_BITS +: COORD_BITS];
	assign a_yl = a_box[2*COORD_BITS +: COORD_BITS];
	assign a_yh = a_box[3*COORD_BITS +: COORD_BITS];
	assign b_xl = b_box[0*COORD_BITS +: COORD_BITS];
	assign b_xh = b_box[1*COORD_BITS +: COORD_BITS];
	assign b_yl = b_box[2*COORD_BITS +: COORD_BITS];
	assign b_yh = b_box[3*COORD_BITS +: COORD_BITS];

	// touching edges count as overlap
	assign hit = (a_xl <= b_xh) && (b_xl <= a_xh) &&
		(a_yl <= b_yh) && (b_yl <= a_yh);

endmodule

>>> src/box_set_overlap_finder_core.sv
// Load: boxes are taken while idle, the block ready again in the next cycle.
// Run: per first-set row a fetch state, a scan over the second set and an emit state,
// the emit waiting while the previous row is still offered; the scan is set by the single
// second-set read port feeding the shared pair compare unit, one pair a cycle.
// Reset: asynchronous, clears control, counts and the output beat; box stores
// hold no reset value and must be loaded before use.
module box_set_overlap_finder_core #(
	parameter int unsigned MAX_BOXES  = bsof_pkg::MAX_BOXES_DEF,
	parameter int unsigned COORD_BITS = bsof_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_write_en,
	input  logic [bsof_pkg::CFG_IX_W-1:0]      cfg_index,
	input  logic [bsof_pkg::CNT_W-1:0]         cfg_data,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [bsof_pkg::MODE_W-1:0]        mode,
	input  logic [bsof_pkg::SLOT_W-1:0]        slot,
	input  logic signed [bsof_pkg::FIELD_W-1:0] x_low,
	input  logic signed [bsof_pkg::FIELD_W-1:0] x_high,
	input  logic signed [bsof_pkg::FIELD_W-1:0] y_low,
	input  logic signed [bsof_pkg::FIELD_W-1:0] y_high,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [bsof_pkg::SLOT_W-1:0]        first_set_entry,
	output logic [bsof_pkg::MASK_W-1:0]        hit_mask,
	output logic                               last_row
);
	import bsof_pkg::*;

	localparam int unsigned IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int unsigned BOX_W = 4 * COORD_BITS;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BOXES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD_A,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       first_cnt_q, second_cnt_q;
	logic [CNT_W-1:0]       na, nb;
	logic [CNT_W-1:0]       i_q, j_q;
	logic [IDX_W-1:0]       j_s1;
	logic                   jv_s1;
	logic [MASK_W-1:0]      mask_q;
	logic                   out_valid_q;
	logic [SLOT_W-1:0]      entry_q;
	logic [MASK_W-1:0]      hit_mask_q;
	logic                   last_q;

	logic [BOX_W-1:0]       first_mem [MAX_BOXES];
	logic [BOX_W-1:0]       second_mem [MAX_BOXES];
	logic [BOX_W-1:0]       a_s1, b_s1;
	logic [BOX_W-1:0]       wr_box;
	logic                   in_beat, slot_ok, pair_hit, last_i;

	// handshake
	assign in_stall = (state_q != ST_IDLE);
	assign in_beat  = in_valid && !in_stall;

	// counts saturate at the store depth
	assign na = (first_cnt_q > MAX_CNT) ? MAX_CNT : first_cnt_q;
	assign nb = (second_cnt_q > MAX_CNT) ? MAX_CNT : second_cnt_q;
	assign last_i = ((i_q + CNT_W'(1)) == na);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_FIRST_COUNT:  first_cnt_q  <= cfg_data;
				REG_SECOND_COUNT: second_cnt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// box stores: low COORD_BITS of each edge, sign taken at compare
	assign wr_box = {y_high[COORD_BITS-1:0], y_low[COORD_BITS-1:0],
		x_high[COORD_BITS-1:0], x_low[COORD_BITS-1:0]};
	assign slot_ok = ({1'b0, slot} < MAX_CNT);

	always_ff @(posedge clk) begin
		if (in_beat && slot_ok && (mode == MODE_LOAD_FIRST)) begin
			first_mem[slot[IDX_W-1:0]] <= wr_box;
		end
		a_s1 <= first_mem[i_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (in_beat && slot_ok && (mode == MODE_LOAD_SECOND)) begin
			second_mem[slot[IDX_W-1:0]] <= wr_box;
		end
		b_s1 <= second_mem[j_q[IDX_W-1:0]];
	end

	// shared compare unit
	bsof_pair_cmp #(
		.COORD_BITS (COORD_BITS)
	) u_cmp (
		.a_box (a_s1),
		.b_box (b_s1),
		.hit   (pair_hit)
	);

	// sequencer: row by row, one second-set box per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			j_s1        <= '0;
			jv_s1       <= 1'b0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
			entry_q     <= '0;
			hit_mask_q  <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat && (mode == MODE_RUN) && (na != '0)) begin
						i_q     <= '0;
						state_q <= ST_LOAD_A;
					end
				end
				ST_LOAD_A: begin
					j_q     <= '0;
					jv_s1   <= 1'b0;
					mask_q  <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (j_q < nb) begin
						jv_s1 <= 1'b1;
						j_s1  <= j_q[IDX_W-1:0];
						j_q   <= j_q + CNT_W'(1);
					end else begin
						jv_s1 <= 1'b0;
					end
					if (jv_s1 && pair_hit) begin
						mask_q[j_s1] <= 1'b1;
					end
					if ((j_q >= nb) && !jv_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						entry_q     <= i_q[SLOT_W-1:0];
						hit_mask_q  <= mask_q;
						last_q      <= last_i;
						if (last_i) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + CNT_W'(1);
							state_q <= ST_LOAD_A;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign first_set_entry = entry_q;
	assign hit_mask        = hit_mask_q;
	assign last_row        = last_q;

endmodule

>>> src/bsof_checker.sv
// Port-level checks for the overlap finder and their binding to the top level.
module bsof_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [bsof_pkg::MODE_W-1:0]   mode,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          last_row
);
	import bsof_pkg::*;

	// a stalled output beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// loads and ignored items leave the block ready next cycle
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (mode == MODE_LOAD_FIRST || mode == MODE_LOAD_SECOND
		|| mode == MODE_NONE) |=> !in_stall)
		else $error("block busy after a load beat");

	// a row other than the last is taken while the run still goes on
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_row |=> in_stall)
		else $error("block idle before the last row");

	// a row pending while idle must be the final row of its run
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_stall |-> last_row)
		else $error("idle with a non-final row pending");

endmodule

bind box_set_overlap_finder_core bsof_checker u_bsof_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.mode      (mode),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.last_row  (last_row)
);
